FILE: rtl/rmts_pkg.sv
`default_nettype none

package rmts_pkg;

   // Fixed field widths of the scheduler.
   localparam int MAX_TASKS   = 4;
   localparam int TASK_W      = 2;
   localparam int PERIOD_W    = 16;
   localparam int BUDGET_W    = 16;
   localparam int TIME_W      = 32;
   localparam int JOB_W       = 32;
   localparam int REM_CNT_W   = $clog2(TIME_W);

   // Configuration port.
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   // Register indexes: periods first, then budgets.
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_BASE = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUDGET_BASE = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT       = 4'd8;

   // Stream widths.
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 120;
   localparam int RSP_TUSER_W = 3;

   // Token handed from one task cell to the next during a tick.
   typedef struct packed {
      logic                found;
      logic [TASK_W-1:0]   index;
      logic [PERIOD_W-1:0] period;
      logic [JOB_W-1:0]    job;
      logic [BUDGET_W-1:0] budget_left;
      logic                miss;
      logic [TASK_W-1:0]   miss_index;
   } chain_type;

   // Per-tick control broadcast to all cells.
   typedef struct packed {
      logic              restart;
      logic              now_zero;
      logic              wrap;
      logic              commit;
      logic              win_found;
      logic [TASK_W-1:0] win_index;
   } tick_ctrl_type;

   // Control of the bit-serial remainder pass.
   typedef struct packed {
      logic clear;
      logic step;
      logic bit_in;
   } rem_ctrl_type;

endpackage

`default_nettype wire

FILE: rtl/rmts_cell.sv
`default_nettype none

// One task of the scheduler: phase within the period, budget, ready flag
// and job count. Passes the best candidate so far to the next cell.
module rmts_cell #(
   parameter int INDEX = 0
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [rmts_pkg::PERIOD_W-1:0]      period_cfg,
   input  wire  [rmts_pkg::BUDGET_W-1:0]      budget_cfg,
   input  rmts_pkg::tick_ctrl_type            tick,
   input  rmts_pkg::rem_ctrl_type             rem_ctrl,
   input  rmts_pkg::chain_type                chain_in,
   output rmts_pkg::chain_type                chain_out
);

   localparam int PW = rmts_pkg::PERIOD_W;
   localparam int BW = rmts_pkg::BUDGET_W;
   localparam int JW = rmts_pkg::JOB_W;
   localparam int TW = rmts_pkg::TASK_W;
   localparam logic [JW-1:0] ONE_JOB   = 1;
   localparam logic [PW:0]   ONE_PHASE = 1;
   localparam logic [TW-1:0] MY_INDEX  = TW'(INDEX);

   logic [PW-1:0] rem_ff, rem_in;
   logic [BW-1:0] budget_ff, budget_in;
   logic          ready_ff, ready_in;
   logic [JW-1:0] jobs_ff, jobs_in;

   logic [PW-1:0] rem_eff;
   logic [BW-1:0] budget_eff, budget_new, budget_dec;
   logic          ready_eff, ready_new;
   logic [JW-1:0] jobs_eff, job_now;
   logic          enabled, released, miss_self, take, winner, done;
   logic [PW:0]   phase_inc, rem_shift, rem_sub;
   logic [PW-1:0] rem_tick;

   always_comb begin
      rem_eff    = tick.restart ? '0 : rem_ff;
      budget_eff = tick.restart ? '0 : budget_ff;
      ready_eff  = tick.restart ? 1'b0 : ready_ff;
      jobs_eff   = tick.restart ? '0 : jobs_ff;

      enabled    = (period_cfg != '0);
      released   = enabled && (rem_eff == '0);
      miss_self  = released && (budget_eff != '0) && !tick.now_zero;
      ready_new  = ready_eff | released;
      budget_new = released ? budget_cfg : budget_eff;
      budget_dec = (budget_new == '0) ? '0 : budget_new - BW'(1);
      job_now    = jobs_eff + ONE_JOB;

      take = ready_new && (!chain_in.found || (period_cfg < chain_in.period));
      chain_out = chain_in;
      if (take) begin
         chain_out.found       = 1'b1;
         chain_out.index       = MY_INDEX;
         chain_out.period      = period_cfg;
         chain_out.job         = job_now;
         chain_out.budget_left = budget_dec;
      end
      if (!chain_in.miss && miss_self) begin
         chain_out.miss       = 1'b1;
         chain_out.miss_index = MY_INDEX;
      end

      winner = tick.win_found && (tick.win_index == MY_INDEX);
      done   = winner && (budget_dec == '0);

      // Phase moves on by one tick and folds back at the period; it is zero when disabled or at time wrap.
      phase_inc = {1'b0, rem_eff} + ONE_PHASE;
      if (!enabled || tick.wrap) begin
         rem_tick = '0;
      end else if (phase_inc == {1'b0, period_cfg}) begin
         rem_tick = '0;
      end else begin
         rem_tick = phase_inc[PW-1:0];
      end

      // One restoring division step: bring in the next time bit.
      rem_shift = {rem_ff, rem_ctrl.bit_in};
      rem_sub   = rem_shift - {1'b0, period_cfg};

      rem_in    = rem_ff;
      budget_in = budget_ff;
      ready_in  = ready_ff;
      jobs_in   = jobs_ff;
      if (rem_ctrl.clear) begin
         rem_in = '0;
      end else if (rem_ctrl.step) begin
         rem_in = (rem_shift >= {1'b0, period_cfg}) ? rem_sub[PW-1:0] : rem_shift[PW-1:0];
      end else if (tick.commit) begin
         rem_in    = rem_tick;
         budget_in = winner ? budget_dec : budget_new;
         ready_in  = ready_new && !done;
         jobs_in   = done ? job_now : jobs_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff    <= '0;
         budget_ff <= '0;
         ready_ff  <= 1'b0;
         jobs_ff   <= '0;
      end else begin
         rem_ff    <= rem_in;
         budget_ff <= budget_in;
         ready_ff  <= ready_in;
         jobs_ff   <= jobs_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rate_monotonic_tick_scheduler_core.sv
// Throughput: one tick beat per cycle unless a remainder pass runs or results stall; results
// pass the decision and output stages. A period write starts a remainder pass (one time bit
// per cycle in every task cell) that holds off tick beats; budget writes take effect at once.
// Reset is synchronous and active high: it clears time, task state, the halt flag and the
// pipeline, sets all periods to zero and all budgets to one; no clearing pass is needed.
`default_nettype none

module rate_monotonic_tick_scheduler_core #(
   parameter int NUM_TASKS = 4
) (
   input  wire                                  clock,
   input  wire                                  reset,

   // Tick stream. tdata: restart (bit 0), zero padded.
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [rmts_pkg::REQ_TDATA_W-1:0]     req_tdata,

   // Result stream. tdata from bit 0: tick_time (32), running_task (2), job_number (32),
   // job_deadline (32), budget_left (16), missed_task (2), zero padded.
   // tuser from bit 0: idle, deadline_miss, stopped.
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [rmts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [rmts_pkg::RSP_TUSER_W-1:0]     rsp_tuser,

   // Configuration write channel.
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire  [rmts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [rmts_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int MT = rmts_pkg::MAX_TASKS;
   localparam int PW = rmts_pkg::PERIOD_W;
   localparam int BW = rmts_pkg::BUDGET_W;
   localparam int TW = rmts_pkg::TASK_W;
   localparam int JW = rmts_pkg::JOB_W;
   localparam int TIW = rmts_pkg::TIME_W;
   localparam int CW = rmts_pkg::REM_CNT_W;
   localparam int PAD_W = rmts_pkg::RSP_TDATA_W - (TIW + TW + JW + JW + BW + TW);
   localparam logic [TIW-1:0] ONE_TICK = 1;
   localparam logic [CW-1:0]  LAST_BIT = CW'(TIW - 1);

   // Configuration registers. Periods of tasks the core does not build are kept but unused.
   logic [PW-1:0] period_ff [MT];
   logic [BW-1:0] budget_ff [MT];

   // Global run state.
   logic [TIW-1:0] time_ff, time_in;
   logic           halted_ff, halted_in;

   // Remainder pass sequencer.
   logic           rec_busy_ff, rec_busy_in;
   logic [CW-1:0]  rec_cnt_ff, rec_cnt_in;
   logic [CW-1:0]  rec_bit_pos;

   // First pipeline stage (scheduling decision) and output stage.
   logic           s1_valid_ff, s1_valid_in;
   logic [TIW-1:0] s1_time_ff;
   logic           s1_idle_ff, s1_miss_ff, s1_stopped_ff;
   logic [TW-1:0]  s1_run_ff, s1_missed_ff;
   logic [JW-1:0]  s1_job_ff;
   logic [PW-1:0]  s1_period_ff;
   logic [BW-1:0]  s1_budget_ff;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [TIW-1:0] out_time_ff;
   logic           out_idle_ff, out_miss_ff, out_stopped_ff;
   logic [TW-1:0]  out_run_ff, out_missed_ff;
   logic [JW-1:0]  out_job_ff, out_deadline_ff;
   logic [BW-1:0]  out_budget_ff;

   // Tick evaluation.
   logic           accept, restart, halted_eff, go, commit, miss_now, run_now, out_load;
   logic [TIW-1:0] now;
   logic           csr_wr, csr_period_wr, csr_budget_wr;
   logic [PW+JW-1:0] product;

   rmts_pkg::chain_type     chain [NUM_TASKS+1];
   rmts_pkg::tick_ctrl_type tick;
   rmts_pkg::rem_ctrl_type  rem_ctrl;

   // ------------------------------------------------------------------------------------
   // Configuration. The port is always ready. A new period changes the phase of that task
   // against the current time, so every period write reruns the remainder pass.
   // ------------------------------------------------------------------------------------
   assign csr_ready     = 1'b1;
   assign csr_wr        = csr_valid && csr_ready;
   assign csr_period_wr = csr_wr && (csr_index < rmts_pkg::CSR_BUDGET_BASE);
   assign csr_budget_wr = csr_wr && (csr_index >= rmts_pkg::CSR_BUDGET_BASE)
                          && (csr_index < rmts_pkg::CSR_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MT; i++) begin
            period_ff[i] <= '0;
            budget_ff[i] <= BW'(1);
         end
      end else if (csr_period_wr) begin
         period_ff[csr_index[TW-1:0]] <= csr_data;
      end else if (csr_budget_wr) begin
         budget_ff[csr_index[TW-1:0]] <= csr_data;
      end
   end

   // ------------------------------------------------------------------------------------
   // Remainder pass. Each cell keeps its phase, time modulo its period. After a period
   // write the phases are rebuilt by long division of the time, most significant bit first,
   // one bit per cycle in all cells together.
   // ------------------------------------------------------------------------------------
   assign rec_bit_pos = LAST_BIT - rec_cnt_ff;

   always_comb begin
      rem_ctrl.clear  = csr_period_wr;
      rem_ctrl.step   = rec_busy_ff && !csr_period_wr;
      rem_ctrl.bit_in = time_ff[rec_bit_pos];

      rec_cnt_in  = rec_cnt_ff;
      rec_busy_in = rec_busy_ff;
      if (csr_period_wr) begin
         rec_cnt_in  = '0;
         rec_busy_in = 1'b1;
      end else if (rem_ctrl.step) begin
         rec_cnt_in  = rec_cnt_ff + CW'(1);
         rec_busy_in = (rec_cnt_ff != LAST_BIT);
      end
   end

   // ------------------------------------------------------------------------------------
   // Tick evaluation. A restart tick sees time zero and cleared task state. While halted
   // a tick changes nothing and merely reports the frozen time.
   // ------------------------------------------------------------------------------------
   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !rec_busy_ff && (!s1_valid_ff || out_load);
   assign accept     = req_tvalid && req_tready;
   assign restart    = req_tdata[0];
   assign now        = restart ? '0 : time_ff;
   assign halted_eff = halted_ff && !restart;
   assign go         = accept && !halted_eff;
   assign miss_now   = go && chain[NUM_TASKS].miss;
   assign commit     = go && !chain[NUM_TASKS].miss;
   assign run_now    = commit && chain[NUM_TASKS].found;

   always_comb begin
      tick.restart   = restart && accept;
      tick.now_zero  = (now == '0);
      tick.wrap      = (now == '1);
      tick.commit    = commit;
      tick.win_found = chain[NUM_TASKS].found;
      tick.win_index = chain[NUM_TASKS].index;
   end

   // The chain starts empty; each cell may take over the best candidate (shortest period,
   // earlier cell on ties) and the first deadline miss.
   assign chain[0] = '0;

   for (genvar g = 0; g < NUM_TASKS; g++) begin : gen_cell
      rmts_cell #(
         .INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .period_cfg (period_ff[g]),
         .budget_cfg (budget_ff[g]),
         .tick       (tick),
         .rem_ctrl   (rem_ctrl),
         .chain_in   (chain[g]),
         .chain_out  (chain[g+1])
      );
   end

   // Time moves on only on a tick that ran to the end; a miss freezes it and halts.
   assign time_in   = commit ? now + ONE_TICK : time_ff;
   assign halted_in = accept ? (halted_eff || miss_now) : halted_ff;

   // ------------------------------------------------------------------------------------
   // Pipeline. Stage one holds the decision, the output stage forms the deadline product.
   // ------------------------------------------------------------------------------------
   assign s1_valid_in  = accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff      <= '0;
         halted_ff    <= 1'b0;
         rec_busy_ff  <= 1'b0;
         rec_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_ff      <= time_in;
         halted_ff    <= halted_in;
         rec_busy_ff  <= rec_busy_in;
         rec_cnt_ff   <= rec_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_time_ff    <= now;
         s1_idle_ff    <= !run_now;
         s1_miss_ff    <= miss_now;
         s1_stopped_ff <= halted_eff || miss_now;
         s1_missed_ff  <= miss_now ? chain[NUM_TASKS].miss_index : '0;
         s1_run_ff     <= run_now ? chain[NUM_TASKS].index : '0;
         s1_job_ff     <= run_now ? chain[NUM_TASKS].job : '0;
         s1_period_ff  <= run_now ? chain[NUM_TASKS].period : '0;
         s1_budget_ff  <= run_now ? chain[NUM_TASKS].budget_left : '0;
      end
   end

   assign product = {{JW{1'b0}}, s1_period_ff} * {{PW{1'b0}}, s1_job_ff};

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_time_ff     <= s1_time_ff;
         out_idle_ff     <= s1_idle_ff;
         out_miss_ff     <= s1_miss_ff;
         out_stopped_ff  <= s1_stopped_ff;
         out_missed_ff   <= s1_missed_ff;
         out_run_ff      <= s1_run_ff;
         out_job_ff      <= s1_job_ff;
         out_deadline_ff <= product[JW-1:0];
         out_budget_ff   <= s1_budget_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_missed_ff, out_budget_ff, out_deadline_ff,
                        out_job_ff, out_run_ff, out_time_ff};
   assign rsp_tuser  = {out_stopped_ff, out_miss_ff, out_idle_ff};

   // ------------------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------------------

   // A period write must hold off ticks while the phases are rebuilt.
   assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && csr_index < rmts_pkg::CSR_BUDGET_BASE) |=> !req_tready)
      else $error("tick accepted during remainder pass");

   // A detected miss halts the scheduler and freezes time.
   assert property (@(posedge clock) disable iff (reset)
      miss_now |=> (halted_ff && $stable(time_ff)))
      else $error("miss did not halt the scheduler");

   // A tick taken while halted leaves time and the halt flag untouched.
   assert property (@(posedge clock) disable iff (reset)
      (accept && halted_eff) |=> (halted_ff && $stable(time_ff)))
      else $error("halted tick changed the run state");

   // A miss result is always reported as idle and stopped.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[1]) |-> (rsp_tuser[0] && rsp_tuser[2]))
      else $error("miss result not idle and stopped");

endmodule

`default_nettype wire
